// File: sv/gbn_pkg.sv
// Package: constants, command type and slot arithmetic for the go-back-n sender window.
`timescale 1ns / 1ps
`default_nettype none
package gbn_pkg;

  localparam int WINDOW_MAX  = 8;
  localparam int SEQ_BITS    = 32;
  localparam int MAX_RESULTS = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam int SLOT_BITS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_BITS  = $clog2(WINDOW_MAX + 1);
  localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam int BURST_MAX = (MAX_RESULTS < WINDOW_MAX) ? MAX_RESULTS : WINDOW_MAX;

  localparam int PAY_BITS  = 32;
  localparam int OUT_BITS  = 32;
  localparam int TMR_BITS  = 16;
  localparam int WIN_BITS  = 4;
  localparam int CFG_BITS  = 16;
  localparam int CIDX_BITS = 1;

  localparam logic [WIN_BITS-1:0] WINDOW_RESET  = 4'd5;
  localparam logic [TMR_BITS-1:0] TIMEOUT_RESET = 16'd500;

  localparam logic [CIDX_BITS-1:0] REG_WINDOW_SIZE   = 1'd0;
  localparam logic [CIDX_BITS-1:0] REG_TIMEOUT_TICKS = 1'd1;

  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_ACK  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [2:0] KIND_NEW     = 3'd0;
  localparam logic [2:0] KIND_REFUSED = 3'd1;
  localparam logic [2:0] KIND_RETX    = 3'd2;
  localparam logic [2:0] KIND_ACK_OK  = 3'd3;
  localparam logic [2:0] KIND_ACK_IGN = 3'd4;

  typedef struct packed {
    logic                 burst;
    logic                 wr;
    logic [2:0]           kind;
    logic [SEQ_BITS-1:0]  seq;
    logic [PAY_BITS-1:0]  payload;
    logic [SEQ_BITS-1:0]  base;
    logic [SLOT_BITS-1:0] slot;
    logic [CNT_BITS-1:0]  cnt;
  } gbn_cmd_t;

  function automatic logic [SLOT_BITS-1:0] slot_add(input logic [SLOT_BITS-1:0] a,
                                                    input logic [CNT_BITS-1:0] b);
    logic [CNT_BITS:0] s;
    s = (CNT_BITS + 1)'(a) + (CNT_BITS + 1)'(b);
    if (s >= WINDOW_MAX) begin
      s = s - (CNT_BITS + 1)'(WINDOW_MAX);
    end
    return s[SLOT_BITS-1:0];
  endfunction

  function automatic logic [CNT_BITS-1:0] eff_window(input logic [WIN_BITS-1:0] w);
    logic [CNT_BITS-1:0] r;
    if (w == '0) begin
      r = CNT_BITS'(1);
    end else if (w > WINDOW_MAX) begin
      r = CNT_BITS'(WINDOW_MAX);
    end else begin
      r = CNT_BITS'(w);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/gbn_if.sv
// Interfaces: input, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none
interface gbn_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   op;
  logic [gbn_pkg::PAY_BITS-1:0] payload_ref;
  logic [31:0]                  ack_seq;
  modport source (output valid, op, payload_ref, ack_seq, input ready);
  modport sink (input valid, op, payload_ref, ack_seq, output ready);
endinterface

interface gbn_out_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   kind;
  logic [gbn_pkg::OUT_BITS-1:0] seq;
  logic [gbn_pkg::PAY_BITS-1:0] payload_out;
  logic [gbn_pkg::OUT_BITS-1:0] window_base;
  logic                         last;
  modport source (output valid, kind, seq, payload_out, window_base, last, input ready);
  modport sink (input valid, kind, seq, payload_out, window_base, last, output ready);
endinterface

interface gbn_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gbn_pkg::CIDX_BITS-1:0] index;
  logic [gbn_pkg::CFG_BITS-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/gbn_front.sv
// Front end: config registers, window and timer state, command classification.
`timescale 1ns / 1ps
`default_nettype none
module gbn_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  gbn_in_if.sink                 in_ch,
  gbn_cfg_if.sink                cfg_ch,
  input  wire logic              q_full,
  output logic                   push,
  output gbn_pkg::gbn_cmd_t      cmd
);

  logic [gbn_pkg::WIN_BITS-1:0]  window_r;
  logic [gbn_pkg::TMR_BITS-1:0]  timeout_r;
  logic [gbn_pkg::SEQ_BITS-1:0]  base_r, base_nxt;
  logic [gbn_pkg::SEQ_BITS-1:0]  next_r, next_nxt;
  logic [gbn_pkg::SLOT_BITS-1:0] bslot_r, bslot_nxt;
  logic [gbn_pkg::TMR_BITS-1:0]  tcount_r, tcount_nxt;
  logic                          trun_r, trun_nxt;

  logic                          accept;
  logic [gbn_pkg::SEQ_BITS-1:0]  outs_full;
  logic [gbn_pkg::CNT_BITS-1:0]  outs;
  logic [gbn_pkg::SEQ_BITS-1:0]  ack;
  logic [gbn_pkg::SEQ_BITS-1:0]  off;
  logic                          ack_ok;
  logic [gbn_pkg::CNT_BITS-1:0]  off_inc;
  logic [gbn_pkg::TMR_BITS-1:0]  limit;
  logic [gbn_pkg::TMR_BITS-1:0]  tcount_inc;

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;

  assign outs_full  = next_r - base_r;
  assign outs       = outs_full[gbn_pkg::CNT_BITS-1:0];
  assign ack        = in_ch.ack_seq[gbn_pkg::SEQ_BITS-1:0];
  assign off        = ack - base_r;
  assign ack_ok     = off < gbn_pkg::SEQ_BITS'(outs);
  assign off_inc    = off[gbn_pkg::CNT_BITS-1:0] + gbn_pkg::CNT_BITS'(1);
  assign limit      = (timeout_r == '0) ? gbn_pkg::TMR_BITS'(1) : timeout_r;
  assign tcount_inc = tcount_r + gbn_pkg::TMR_BITS'(1);

  always_comb begin
    base_nxt   = base_r;
    next_nxt   = next_r;
    bslot_nxt  = bslot_r;
    tcount_nxt = tcount_r;
    trun_nxt   = trun_r;
    push       = 1'b0;
    cmd        = '0;
    cmd.base   = base_r;
    cmd.seq    = next_r;
    cmd.cnt    = gbn_pkg::CNT_BITS'(1);
    case (in_ch.op)
      gbn_pkg::OP_SEND: begin
        push        = accept;
        cmd.payload = in_ch.payload_ref;
        if (outs < gbn_pkg::eff_window(window_r)) begin
          cmd.kind = gbn_pkg::KIND_NEW;
          cmd.wr   = 1'b1;
          cmd.slot = gbn_pkg::slot_add(bslot_r, outs);
          next_nxt = next_r + gbn_pkg::SEQ_BITS'(1);
          if (outs == '0) begin
            tcount_nxt = '0;
            trun_nxt   = 1'b1;
          end
        end else begin
          cmd.kind = gbn_pkg::KIND_REFUSED;
        end
      end
      gbn_pkg::OP_ACK: begin
        push    = accept;
        cmd.seq = ack;
        if (ack_ok) begin
          base_nxt   = ack + gbn_pkg::SEQ_BITS'(1);
          bslot_nxt  = gbn_pkg::slot_add(bslot_r, off_inc);
          tcount_nxt = '0;
          trun_nxt   = (base_nxt != next_r);
          cmd.kind   = gbn_pkg::KIND_ACK_OK;
          cmd.base   = base_nxt;
        end else begin
          cmd.kind = gbn_pkg::KIND_ACK_IGN;
        end
      end
      gbn_pkg::OP_TICK: begin
        if (trun_r) begin
          if (outs == '0) begin
            trun_nxt   = 1'b0;
            tcount_nxt = '0;
          end else if (tcount_inc < limit) begin
            tcount_nxt = tcount_inc;
          end else begin
            tcount_nxt = '0;
            push       = accept;
            cmd.burst  = 1'b1;
            cmd.kind   = gbn_pkg::KIND_RETX;
            cmd.seq    = base_r;
            cmd.slot   = bslot_r;
            cmd.cnt    = (outs > gbn_pkg::BURST_MAX) ?
                         gbn_pkg::CNT_BITS'(gbn_pkg::BURST_MAX) : outs;
          end
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= gbn_pkg::WINDOW_RESET;
      timeout_r <= gbn_pkg::TIMEOUT_RESET;
      base_r    <= '0;
      next_r    <= '0;
      bslot_r   <= '0;
      tcount_r  <= '0;
      trun_r    <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          gbn_pkg::REG_WINDOW_SIZE:   window_r  <= cfg_ch.data[gbn_pkg::WIN_BITS-1:0];
          gbn_pkg::REG_TIMEOUT_TICKS: timeout_r <= cfg_ch.data[gbn_pkg::TMR_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        base_r   <= base_nxt;
        next_r   <= next_nxt;
        bslot_r  <= bslot_nxt;
        tcount_r <= tcount_nxt;
        trun_r   <= trun_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/gbn_queue.sv
// Command queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module gbn_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  gbn_pkg::gbn_cmd_t      push_cmd,
  output logic                   full,
  output logic                   cmd_valid,
  output gbn_pkg::gbn_cmd_t      cmd,
  input  wire logic              pop
);

  gbn_pkg::gbn_cmd_t             q_r [gbn_pkg::QUEUE_DEPTH];
  logic [gbn_pkg::QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [gbn_pkg::QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [gbn_pkg::QCNT_BITS-1:0] count_r, count_nxt;
  logic                          do_push, do_pop;

  assign full      = (count_r == gbn_pkg::QCNT_BITS'(gbn_pkg::QUEUE_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == gbn_pkg::QPTR_BITS'(gbn_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + gbn_pkg::QPTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == gbn_pkg::QPTR_BITS'(gbn_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + gbn_pkg::QPTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + gbn_pkg::QCNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - gbn_pkg::QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// File: sv/gbn_back.sv
// Back end: payload store, result register and retransmit burst sequencer.
`timescale 1ns / 1ps
`default_nettype none
module gbn_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  input  gbn_pkg::gbn_cmd_t      cmd,
  output logic                   pop,
  gbn_out_if.source              out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [gbn_pkg::PAY_BITS-1:0]  store_r [gbn_pkg::WINDOW_MAX];
  logic [gbn_pkg::PAY_BITS-1:0]  rd_data_r;

  logic [1:0]                    state_r, state_nxt;
  logic [gbn_pkg::SEQ_BITS-1:0]  bseq_r;
  logic [gbn_pkg::SEQ_BITS-1:0]  bbase_r;
  logic [gbn_pkg::SLOT_BITS-1:0] bslot_r;
  logic [gbn_pkg::CNT_BITS-1:0]  cnt_r;
  logic [gbn_pkg::CNT_BITS-1:0]  idx_r, idx_nxt;

  logic                          ovalid_r, ovalid_nxt;
  logic [2:0]                    kind_r;
  logic [gbn_pkg::OUT_BITS-1:0]  seq_r;
  logic [gbn_pkg::PAY_BITS-1:0]  pay_r;
  logic [gbn_pkg::OUT_BITS-1:0]  base_r;
  logic                          last_r;

  logic                          out_free;
  logic                          emit;
  logic                          burst_last;

  assign out_ch.valid       = ovalid_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.seq         = seq_r;
  assign out_ch.payload_out = pay_r;
  assign out_ch.window_base = base_r;
  assign out_ch.last        = last_r;

  assign out_free   = !ovalid_r || out_ch.ready;
  assign pop        = (state_r == ST_IDLE) && cmd_valid && (cmd.burst || out_free);
  assign emit       = (state_r == ST_EMIT) && out_free;
  assign burst_last = (idx_r + gbn_pkg::CNT_BITS'(1)) == cnt_r;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          if (cmd.burst) begin
            state_nxt = ST_READ;
            idx_nxt   = '0;
          end else begin
            ovalid_nxt = 1'b1;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          idx_nxt    = idx_r + gbn_pkg::CNT_BITS'(1);
          state_nxt  = burst_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cmd.burst) begin
      bseq_r  <= cmd.seq;
      bbase_r <= cmd.base;
      bslot_r <= cmd.slot;
      cnt_r   <= cmd.cnt;
    end
    if (pop && !cmd.burst) begin
      kind_r <= cmd.kind;
      seq_r  <= gbn_pkg::OUT_BITS'(cmd.seq);
      pay_r  <= cmd.payload;
      base_r <= gbn_pkg::OUT_BITS'(cmd.base);
      last_r <= 1'b1;
    end else if (emit) begin
      kind_r <= gbn_pkg::KIND_RETX;
      seq_r  <= gbn_pkg::OUT_BITS'(bseq_r + gbn_pkg::SEQ_BITS'(idx_r));
      pay_r  <= rd_data_r;
      base_r <= gbn_pkg::OUT_BITS'(bbase_r);
      last_r <= burst_last;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !cmd.burst && cmd.wr) begin
      store_r[cmd.slot] <= cmd.payload;
    end
    if (state_r == ST_READ) begin
      rd_data_r <= store_r[gbn_pkg::slot_add(bslot_r, idx_r)];
    end
  end

`ifndef SYNTHESIS
  a_burst_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (cnt_r != '0) && (idx_r < cnt_r))
    else $error("burst index out of range");
  a_nonlast_retx: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !last_r) |-> (kind_r == gbn_pkg::KIND_RETX))
    else $error("only retransmits may continue a result sequence");
  a_emit_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && burst_last) |=> (state_r == ST_IDLE) && ovalid_r && last_r)
    else $error("burst did not close with a last result");
`endif

endmodule
`default_nettype wire

// File: sv/go_back_n_sender_window.sv
// Top level: go-back-n sender window, front end, command queue and back end.
// A send or ack result passes through the command queue and is then held in the result register.
// Throughput: one send or ack transaction per cycle while the command queue has room; a
// timeout emits up to eight retransmits, each after a registered read of the payload store.
// Input stalls while the two-entry command queue is full.
// Reset (rst_n low, synchronous) clears window and timer state and restores
// window_size 5 and timeout_ticks 500; the payload store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module go_back_n_sender_window (
  input  wire logic clk,
  input  wire logic rst_n,
  gbn_in_if.sink    in_ch,
  gbn_out_if.source out_ch,
  gbn_cfg_if.sink   cfg_ch
);

  logic              q_full;
  logic              push;
  gbn_pkg::gbn_cmd_t push_cmd;
  logic              cmd_valid;
  gbn_pkg::gbn_cmd_t cmd;
  logic              pop;

  gbn_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  gbn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop)
  );

  gbn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

// File: tb/sv/gbn_window_checker.sv
// Checker: predicts go-back-n sender window results and compares them with the block's output.
`timescale 1ns / 1ps
module gbn_window_checker (
  input  logic        clk,
  input  logic        rst_n,
  gbn_in_if           in_ch,
  gbn_out_if          out_ch,
  gbn_cfg_if          cfg_ch,
  output int          n_fail,
  output int          n_pending,
  output int          n_checked,
  output int          n_retx,
  output logic [31:0] win_base,
  output logic [31:0] win_next
);
  import gbn_pkg::*;

  typedef struct packed {
    logic [2:0]          kind;
    logic [SEQ_BITS-1:0] seq;
    logic [PAY_BITS-1:0] payload;
    logic [SEQ_BITS-1:0] base;
    logic                last;
  } tx_result_t;

  tx_result_t          expected_results[$];
  logic [WIN_BITS-1:0] window_reg;
  logic [TMR_BITS-1:0] timeout_reg;
  logic [SEQ_BITS-1:0] base_seq;
  logic [SEQ_BITS-1:0] next_seq;
  logic [TMR_BITS-1:0] tick_count;
  logic                timer_on;
  logic [PAY_BITS-1:0] payload_mem[WINDOW_MAX];
  int unsigned         base_slot;

  function automatic void expect_result(input logic [2:0] kind, input logic [SEQ_BITS-1:0] seq,
                                        input logic [PAY_BITS-1:0] pay, input logic last);
    tx_result_t r;
    r.kind    = kind;
    r.seq     = seq;
    r.payload = pay;
    r.base    = base_seq;
    r.last    = last;
    expected_results.insert(expected_results.size(), r);
  endfunction

  task automatic window_step(input logic [1:0] op, input logic [PAY_BITS-1:0] pay,
                             input logic [SEQ_BITS-1:0] ack);
    logic [SEQ_BITS-1:0] outs;
    logic [SEQ_BITS-1:0] off;
    int unsigned         win;
    int unsigned         limit;
    int unsigned         n;
    outs = next_seq - base_seq;
    if (window_reg == '0) win = 1;
    else if (window_reg > WINDOW_MAX) win = WINDOW_MAX;
    else win = window_reg;
    case (op)
      OP_SEND: begin
        if (outs < win) begin
          payload_mem[(base_slot + outs) % WINDOW_MAX] = pay;
          if (outs == 0) begin
            tick_count = '0;
            timer_on   = 1'b1;
          end
          expect_result(KIND_NEW, next_seq, pay, 1'b1);
          next_seq = next_seq + 1;
        end else begin
          expect_result(KIND_REFUSED, next_seq, pay, 1'b1);
        end
      end
      OP_ACK: begin
        off = ack - base_seq;
        if (off < outs) begin
          base_slot  = (base_slot + off + 1) % WINDOW_MAX;
          base_seq   = ack + 1;
          tick_count = '0;
          timer_on   = (base_seq != next_seq);
          expect_result(KIND_ACK_OK, ack, '0, 1'b1);
        end else begin
          expect_result(KIND_ACK_IGN, ack, '0, 1'b1);
        end
      end
      OP_TICK: begin
        if (timer_on) begin
          if (outs == 0) begin
            timer_on   = 1'b0;
            tick_count = '0;
          end else begin
            limit      = (timeout_reg == '0) ? 1 : timeout_reg;
            tick_count = tick_count + 1;
            if (tick_count >= limit) begin
              tick_count = '0;
              n = (outs < MAX_RESULTS) ? outs : MAX_RESULTS;
              for (int i = 0; i < n; i++) begin
                expect_result(KIND_RETX, base_seq + i,
                              payload_mem[(base_slot + i) % WINDOW_MAX], (i + 1 == n));
              end
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result;
    tx_result_t got;
    tx_result_t want;
    got.kind    = out_ch.kind;
    got.seq     = out_ch.seq;
    got.payload = out_ch.payload_out;
    got.base    = out_ch.window_base;
    got.last    = out_ch.last;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result kind %0d seq %h payload %h base %h last %b",
               $time, got.kind, got.seq, got.payload, got.base, got.last);
      n_fail++;
    end else begin
      want = expected_results.pop_front();
      n_checked++;
      if (want.kind == KIND_RETX) n_retx++;
      if (got !== want) begin
        $display("%0t: mismatch, expected kind %0d seq %h payload %h base %h last %b",
                 $time, want.kind, want.seq, want.payload, want.base, want.last);
        $display("%0t:           actual   kind %0d seq %h payload %h base %h last %b",
                 $time, got.kind, got.seq, got.payload, got.base, got.last);
        n_fail++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      window_reg  = WINDOW_RESET;
      timeout_reg = TIMEOUT_RESET;
      base_seq    = '0;
      next_seq    = '0;
      tick_count  = '0;
      timer_on    = 1'b0;
      base_slot   = 0;
      expected_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_WINDOW_SIZE:   window_reg = cfg_ch.data[WIN_BITS-1:0];
          REG_TIMEOUT_TICKS: timeout_reg = cfg_ch.data[TMR_BITS-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) window_step(in_ch.op, in_ch.payload_ref, in_ch.ack_seq);
    end
    n_pending = expected_results.size();
    win_base  = base_seq;
    win_next  = next_seq;
  end

endmodule

// File: tb/sv/tb.sv
// Testbench top: clock, reset, stimulus and handshake pacing for the go-back-n sender window.
`timescale 1ns / 1ps
module tb;
  import gbn_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         HOLD_CYCLES = 120;
  localparam int         SETTLE      = 24;
  localparam int         STALL_LIMIT = 4000;
  localparam int         PHASE_ITEMS = 25;

  typedef enum logic [1:0] {ACK_GIVEN, ACK_LIVE, ACK_STALE} ack_pick_t;

  logic        clk;
  logic        rst_n;
  int          n_fail;
  int          n_pending;
  int          n_checked;
  int          n_retx;
  logic [31:0] win_base;
  logic [31:0] win_next;
  int          send_idle_pct;
  int          stall_pct;
  int          hold_reqs;
  int          n_items;
  int          n_writes;
  int          quiet;

  gbn_in_if  in_ch ();
  gbn_out_if out_ch ();
  gbn_cfg_if cfg_ch ();

  go_back_n_sender_window uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  gbn_window_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .n_fail    (n_fail),
    .n_pending (n_pending),
    .n_checked (n_checked),
    .n_retx    (n_retx),
    .win_base  (win_base),
    .win_next  (win_next)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin : receiver
    int hold_left;
    int holds_done;
    hold_left      = 0;
    holds_done     = 0;
    out_ch.ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        holds_done = hold_reqs;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic put_item(input logic [1:0] op, input logic [31:0] pay, input logic [31:0] ack,
                          input ack_pick_t pick);
    logic [31:0] outs;
    logic [31:0] a;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    outs = win_next - win_base;
    case (pick)
      ACK_LIVE:  a = (outs != 0) ? win_base + $urandom_range(outs - 1) : ack;
      ACK_STALE: a = win_base - 32'd1 - $urandom_range(3);
      default:   a = ack;
    endcase
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.payload_ref <= pay;
    in_ch.ack_seq     <= a;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_items++;
  endtask

  task automatic wait_drained;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    wait_drained();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    n_writes++;
  endtask

  task automatic random_item;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) put_item(OP_SEND, $urandom, $urandom, ACK_GIVEN);
    else if (r < 62) put_item(OP_ACK, $urandom, $urandom, ACK_LIVE);
    else if (r < 90) put_item(OP_TICK, $urandom, $urandom, ACK_GIVEN);
    else if (r < 94) put_item(OP_ACK, $urandom, $urandom, ACK_GIVEN);
    else if (r < 97) put_item(OP_ACK, $urandom, $urandom, ACK_STALE);
    else put_item(OP_UNUSED, $urandom, $urandom, ACK_GIVEN);
  endtask

  initial begin : stimulus
    logic [3:0]  w;
    logic [11:0] hi;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_SEND;
    in_ch.payload_ref = '0;
    in_ch.ack_seq     = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_WINDOW_SIZE;
    cfg_ch.data       = '0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    hold_reqs         = 0;
    n_items           = 0;
    n_writes          = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default window of five, timer stopped
    put_item(OP_TICK, $urandom, $urandom, ACK_GIVEN);
    put_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ACK_GIVEN);
    put_item(OP_SEND, 32'h0000_0000, 32'h0, ACK_GIVEN);
    put_item(OP_SEND, 32'hFFFF_FFFF, 32'h0, ACK_GIVEN);
    put_item(OP_SEND, 32'hAAAA_AAAA, 32'h0, ACK_GIVEN);
    put_item(OP_SEND, 32'h5555_5555, 32'h0, ACK_GIVEN);
    put_item(OP_SEND, $urandom, 32'h0, ACK_GIVEN);
    put_item(OP_SEND, $urandom, 32'h0, ACK_GIVEN);
    put_item(OP_ACK, 32'h0, 32'hFFFF_FFFF, ACK_GIVEN);
    put_item(OP_ACK, 32'h0, 32'd5, ACK_GIVEN);
    put_item(OP_ACK, 32'h0, 32'd1, ACK_GIVEN);
    put_item(OP_ACK, 32'h0, 32'd0, ACK_GIVEN);
    put_item(OP_ACK, 32'h0, 32'd4, ACK_GIVEN);

    // oversized window acts as eight, zero timeout acts as one
    write_reg(REG_WINDOW_SIZE, 16'hFFFF);
    write_reg(REG_TIMEOUT_TICKS, 16'h0000);
    repeat (9) put_item(OP_SEND, $urandom, $urandom, ACK_GIVEN);
    put_item(OP_TICK, $urandom, $urandom, ACK_GIVEN);

    // shrink the window below what is outstanding
    write_reg(REG_WINDOW_SIZE, 16'd2);
    put_item(OP_SEND, $urandom, $urandom, ACK_GIVEN);
    put_item(OP_ACK, $urandom, 32'd11, ACK_GIVEN);
    put_item(OP_SEND, $urandom, $urandom, ACK_GIVEN);
    put_item(OP_TICK, $urandom, $urandom, ACK_GIVEN);

    // zero window acts as one, longest timeout
    write_reg(REG_WINDOW_SIZE, 16'hFFF0);
    write_reg(REG_TIMEOUT_TICKS, 16'hFFFF);
    put_item(OP_ACK, $urandom, 32'd13, ACK_GIVEN);
    put_item(OP_SEND, $urandom, $urandom, ACK_GIVEN);
    put_item(OP_SEND, $urandom, $urandom, ACK_GIVEN);
    put_item(OP_TICK, $urandom, $urandom, ACK_GIVEN);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 48; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 48; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      w  = (ph == 0) ? 4'd8 : 4'($urandom_range(1, 8));
      hi = $urandom_range(4095);
      write_reg(REG_WINDOW_SIZE, {hi, w});
      write_reg(REG_TIMEOUT_TICKS, (ph == 0) ? 16'd1 : 16'($urandom_range(1, 4)));
      // hold the receiver off while the sender keeps offering
      if (ph == 0) hold_reqs++;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 0 && k == PHASE_ITEMS / 2) wait_drained();
        random_item();
      end
    end

    wait_drained();
    repeat (40) @(negedge clk);
    $display("Drove %0d input transactions and %0d register writes over four pacing profiles.",
             n_items, n_writes);
    $display("Compared %0d results, %0d of them retransmits; %0d mismatches.",
             n_checked, n_retx, n_fail);
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
